FILE: rtl/atc_pkg.sv
// Shared types, constants and tables for the amplifier telemetry converter.
package atc_pkg;

   localparam int CsrIdxWidth = 2;
   localparam int CsrDataWidth = 12;

   // Quotient bits of the output power divider, one pipeline stage per bit.
   localparam int DivQuotBits = 9;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_CAL_HIGH = 2'd0,
      CSR_CAL_LOW  = 2'd1,
      CSR_ATTEN    = 2'd2
   } csr_index_type;

   localparam logic [11:0] CalHighReset = 12'd1833;
   localparam logic [11:0] CalLowReset  = 12'd488;
   localparam logic [4:0]  AttenReset   = 5'd0;

   localparam logic [11:0] GainTopCode = 12'd3781;
   localparam logic [11:0] GainLowCode = 12'd725;

   // Current: 3280*x/45056 = 205*x/2816, and 2816 = 256*11.
   // The /256 is a shift; the /11 is a multiply by ceil(2^15/11), exact below 2^15.
   localparam logic [7:0]  CurNum   = 8'd205;
   localparam logic [11:0] CurRecip = 12'd2979;
   // Voltage factor in Q32.
   localparam logic [24:0] VoltQ32 = 25'd31801355;

   typedef struct packed {
      logic [11:0] lo;
      logic signed [16:0] s;
      logic signed [25:0] b;
   } gain_seg_type;

   function automatic gain_seg_type gain_seg(input logic [3:0] i);
      gain_seg_type g;
      case (i)
         4'd0:    g = '{12'd1515, 17'sd144,   26'sd2402360};
         4'd1:    g = '{12'd1188, 17'sd1003,  26'sd1103292};
         4'd2:    g = '{12'd1005, 17'sd1789,  26'sd166461};
         4'd3:    g = '{12'd897,  17'sd3034,  -26'sd1083166};
         4'd4:    g = '{12'd825,  17'sd4548,  -26'sd2443949};
         4'd5:    g = '{12'd776,  17'sd6685,  -26'sd4206343};
         4'd6:    g = '{12'd746,  17'sd10925, -26'sd7492927};
         4'd7:    g = '{12'd733,  17'sd25205, -26'sd18148432};
         default: g = '{12'd725,  17'sd40960, -26'sd29696000};
      endcase
      return g;
   endfunction

endpackage

FILE: rtl/atc_divider.sv
// Pipelined restoring divider: quotient of 30*numer by a 12-bit divisor, one bit per stage.
module atc_divider
   import atc_pkg::*;
#(
   parameter int Stages = DivQuotBits
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [11:0] numer,   // scaled by 30 here; quotient must stay below 2^Stages
   input  logic [11:0] denom,
   output logic        out_valid,
   output logic [Stages-1:0] quot
);
   // Quotient bits come MSB first; the numerator bits above the quotient
   // width are loaded straight into the first partial remainder.
   logic [20:0] numer_wide;
   assign numer_wide = 21'(numer) * 21'd30;

   logic              v_ff   [1:Stages];
   logic [11:0]       rem_ff [1:Stages];
   logic [Stages-1:0] q_ff   [1:Stages];
   logic [Stages-1:0] n_ff   [1:Stages];
   logic [11:0]       d_ff   [1:Stages];

   genvar k;
   generate
      for (k = 0; k < Stages; k++) begin : g_stage
         logic              v_src;
         logic [11:0]       rem_src;
         logic [Stages-1:0] n_src;
         logic [Stages-1:0] q_src;
         logic [11:0]       d_src;
         logic [12:0]       rem_in;
         logic [13:0]       trial_in;
         if (k == 0) begin : g_first
            assign v_src   = in_valid;
            assign rem_src = 12'(numer_wide[20:Stages]);
            assign n_src   = numer_wide[Stages-1:0];
            assign q_src   = '0;
            assign d_src   = denom;
         end else begin : g_next
            assign v_src   = v_ff[k];
            assign rem_src = rem_ff[k];
            assign n_src   = n_ff[k];
            assign q_src   = q_ff[k];
            assign d_src   = d_ff[k];
         end
         always_comb begin
            rem_in   = {rem_src, n_src[Stages-1]};
            trial_in = {1'b0, rem_in} - {2'b0, d_src};
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[k+1] <= 1'b0;
            end else begin
               v_ff[k+1] <= v_src;
            end
            d_ff[k+1] <= d_src;
            n_ff[k+1] <= {n_src[Stages-2:0], 1'b0};
            if (!trial_in[13]) begin
               rem_ff[k+1] <= trial_in[11:0];
               q_ff[k+1]   <= {q_src[Stages-2:0], 1'b1};
            end else begin
               rem_ff[k+1] <= rem_in[11:0];
               q_ff[k+1]   <= {q_src[Stages-2:0], 1'b0};
            end
         end
      end
   endgenerate

   assign out_valid = v_ff[Stages];
   assign quot      = q_ff[Stages];
endmodule

FILE: rtl/amplifier_telemetry_converter.sv
// Top level of the amplifier telemetry converter.
//
// Usage: drive req_* samples with start high while busy is low; busy is tied
// low, so one reading set is taken every cycle. Each transfer yields exactly
// one result, shown on rsp_* for one cycle with done high; the receiver
// cannot hold results off, and none is needed since nothing ever backs up.
// From start to done each item passes through one input register, a 9-stage
// pipelined divider for output power and one output register. Gain, current
// and voltage go through their own multiply stages and are delayed to line
// up with the divider. Throughput: one item per cycle.
// The csr_* port writes power_cal_high (0), power_cal_low (1) and
// attenuation_db (2); writes to other indexes are dropped. Registers are
// sampled with the item at the input stage, so writes take effect for the
// next transfer. Synchronous reset clears the pipeline valid bits and loads
// the calibration defaults.
module amplifier_telemetry_converter
   import atc_pkg::*;
#(
   parameter int DivStages = DivQuotBits
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [11:0] req_power_sample,
   input  logic [11:0] req_current_sample,
   input  logic [11:0] req_gain_sample,
   input  logic [11:0] req_voltage_sample,
   output logic        done,
   output logic signed [5:0] rsp_output_power_dbm,
   output logic [5:0]  rsp_gain_db,
   output logic [7:0]  rsp_current_ma,
   output logic [4:0]  rsp_voltage_v,
   output logic signed [7:0] rsp_input_power_dbm,
   output logic        rsp_calibration_bad,
   input  logic        csr_we,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0] csr_wdata
);
   localparam int Lat = DivStages;

   // how output power is formed at the output stage
   typedef enum logic [1:0] {
      PM_DIVIDE,   // calibrated line through the divider
      PM_ZERO,     // above the high code, or bad calibration
      PM_FLOOR     // below the low code: -30 dBm
   } power_mode_type;

   typedef enum logic [1:0] {
      GM_CURVE,    // piecewise-linear segment
      GM_TOP,      // saturated at 45 dB
      GM_ZERO      // below the first breakpoint
   } gain_mode_type;

   assign busy = 1'b0;

   // ---- configuration registers
   logic [11:0] cal_high_ff, cal_low_ff;
   logic [4:0]  atten_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_high_ff <= CalHighReset;
         cal_low_ff  <= CalLowReset;
         atten_ff    <= AttenReset;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CAL_HIGH: cal_high_ff <= csr_wdata;
            CSR_CAL_LOW:  cal_low_ff  <= csr_wdata;
            CSR_ATTEN:    atten_ff    <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // ---- stage 0: input registers and power classification
   logic           v0_ff;
   power_mode_type pmode_ff;
   logic [11:0]    pnum_ff, pden_ff;
   logic           bad_ff;
   logic [11:0]    gs_ff, cs_ff, vs_ff;
   logic [4:0]     att0_ff;
   logic           bad_in;
   power_mode_type pmode_in;
   always_comb begin
      bad_in = cal_high_ff <= cal_low_ff;
      // high clamp wins over the low one
      if (req_power_sample > cal_high_ff)      pmode_in = PM_ZERO;
      else if (req_power_sample < cal_low_ff)  pmode_in = PM_FLOOR;
      else if (bad_in)                         pmode_in = PM_ZERO;
      else                                     pmode_in = PM_DIVIDE;
   end
   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else       v0_ff <= start;
      pmode_ff <= pmode_in;
      pnum_ff  <= cal_high_ff - req_power_sample;
      pden_ff  <= cal_high_ff - cal_low_ff;
      bad_ff   <= bad_in;
      gs_ff    <= req_gain_sample;
      cs_ff    <= req_current_sample;
      vs_ff    <= req_voltage_sample;
      att0_ff  <= atten_ff;
   end

   logic                 div_v;
   logic [DivStages-1:0] div_q;
   atc_divider #(.Stages(DivStages)) u_div (
      .clock(clock), .reset(reset), .in_valid(v0_ff),
      .numer(pnum_ff), .denom(pden_ff),
      .out_valid(div_v), .quot(div_q)
   );

   // ---- side path stage 1: products
   gain_seg_type seg, seg_try;
   logic [3:0]   seg_idx;
   always_comb begin
      // lowest-numbered segment whose lower bound is met
      seg_idx = 4'd8;
      for (int i = 7; i >= 0; i--) begin
         seg_try = gain_seg(4'(i));
         if (gs_ff >= seg_try.lo) seg_idx = 4'(i);
      end
      seg = gain_seg(seg_idx);
   end
   logic signed [30:0] gprod_ff;
   logic signed [25:0] gb_ff;
   gain_mode_type      gmode_ff;
   logic [19:0]        cprod_ff;
   logic [36:0]        vprod_ff;
   always_ff @(posedge clock) begin
      gprod_ff <= seg.s * $signed({1'b0, gs_ff});
      gb_ff    <= seg.b;
      gmode_ff <= (gs_ff >= GainTopCode) ? GM_TOP : (gs_ff < GainLowCode) ? GM_ZERO : GM_CURVE;
      cprod_ff <= 20'(cs_ff) * 20'(CurNum);
      vprod_ff <= 37'(vs_ff) * 37'(VoltQ32);
   end

   // ---- side path stage 2: finish gain, current, voltage
   logic signed [31:0] gsum;
   logic [5:0]  gain_in;
   logic [23:0] cur_prod;
   logic [8:0]  cur_q;
   always_comb begin
      gsum = 32'(gprod_ff) + 32'(gb_ff);
      case (gmode_ff)
         GM_TOP:  gain_in = 6'd45;
         GM_ZERO: gain_in = 6'd0;
         default: gain_in = gsum[31] ? 6'd0 : gsum[21:16];
      endcase
      // drop the /256 first, then divide by 11 through the reciprocal
      cur_prod = 24'(cprod_ff[19:8]) * 24'(CurRecip);
      cur_q    = cur_prod[23:15];
   end
   logic [5:0] g2_ff;
   logic [7:0] c2_ff;
   logic [4:0] v2_ff;
   always_ff @(posedge clock) begin
      g2_ff <= gain_in;
      c2_ff <= cur_q[8] ? 8'd255 : cur_q[7:0];
      v2_ff <= vprod_ff[36:32];
   end

   // delay line for side results to meet the divider output
   localparam int SideDly = Lat - 2;
   logic [5:0]     gd_ff [1:SideDly];
   logic [7:0]     cd_ff [1:SideDly];
   logic [4:0]     vd_ff [1:SideDly];
   power_mode_type pm_ff [1:Lat];
   logic           bd_ff [1:Lat];
   logic [4:0]     ad_ff [1:Lat];
   always_ff @(posedge clock) begin
      gd_ff[1] <= g2_ff;
      cd_ff[1] <= c2_ff;
      vd_ff[1] <= v2_ff;
      pm_ff[1] <= pmode_ff;
      bd_ff[1] <= bad_ff;
      ad_ff[1] <= att0_ff;
      for (int i = 1; i < SideDly; i++) begin
         gd_ff[i+1] <= gd_ff[i];
         cd_ff[i+1] <= cd_ff[i];
         vd_ff[i+1] <= vd_ff[i];
      end
      for (int i = 1; i < Lat; i++) begin
         pm_ff[i+1] <= pm_ff[i];
         bd_ff[i+1] <= bd_ff[i];
         ad_ff[i+1] <= ad_ff[i];
      end
   end

   // ---- output stage
   logic signed [5:0] pout_in;
   logic signed [7:0] pin_in;
   always_comb begin
      case (pm_ff[Lat])
         PM_ZERO:  pout_in = 6'sd0;
         PM_FLOOR: pout_in = -6'sd30;
         default:  pout_in = -$signed(6'(div_q));
      endcase
      pin_in = 8'(pout_in) - $signed({2'b0, gd_ff[SideDly]})
               + $signed({3'b0, ad_ff[Lat]});
   end
   always_ff @(posedge clock) begin
      if (reset) done <= 1'b0;
      else       done <= div_v;
      rsp_output_power_dbm <= pout_in;
      rsp_gain_db          <= gd_ff[SideDly];
      rsp_current_ma       <= cd_ff[SideDly];
      rsp_voltage_v        <= vd_ff[SideDly];
      rsp_input_power_dbm  <= pin_in;
      rsp_calibration_bad  <= bd_ff[Lat];
   end

   // ---- checks
   a_pout_range: assert property (@(posedge clock) disable iff (reset)
      done |-> (rsp_output_power_dbm <= 0 && rsp_output_power_dbm >= -30))
      else $error("output power out of range");
   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      done |-> rsp_gain_db <= 6'd45)
      else $error("gain out of range");
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (done && rsp_calibration_bad) |->
         (rsp_output_power_dbm == 0 || rsp_output_power_dbm == -30))
      else $error("bad calibration gave a divided power");
endmodule

FILE: bench/tb_amplifier_telemetry_converter.sv
// Self-checking testbench for the amplifier telemetry converter.
`timescale 1ns / 100ps

module tb_amplifier_telemetry_converter;
   import atc_pkg::*;

   typedef struct packed {
      logic [11:0] power;
      logic [11:0] current;
      logic [11:0] gain;
      logic [11:0] voltage;
   } reading_set_type;

   typedef struct packed {
      logic signed [5:0] pout;
      logic [5:0]        gain;
      logic [7:0]        cur;
      logic [4:0]        volt;
      logic signed [7:0] pin;
      logic              bad;
   } telemetry_type;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic [11:0] req_power_sample, req_current_sample, req_gain_sample, req_voltage_sample;
   logic done;
   logic signed [5:0] rsp_output_power_dbm;
   logic [5:0] rsp_gain_db;
   logic [7:0] rsp_current_ma;
   logic [4:0] rsp_voltage_v;
   logic signed [7:0] rsp_input_power_dbm;
   logic rsp_calibration_bad;
   logic csr_we;
   logic [CsrIdxWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0] csr_wdata;

   amplifier_telemetry_converter i_dut (
      .clock, .reset, .start, .busy,
      .req_power_sample, .req_current_sample, .req_gain_sample, .req_voltage_sample,
      .done, .rsp_output_power_dbm, .rsp_gain_db, .rsp_current_ma, .rsp_voltage_v,
      .rsp_input_power_dbm, .rsp_calibration_bad,
      .csr_we, .csr_index, .csr_wdata
   );

   // Shadow copy of the calibration registers.
   logic [11:0] cal_high, cal_low;
   logic [4:0]  atten;

   reading_set_type pending_sets[$];
   int              pending_gaps[$];
   telemetry_type   expected_telemetry[$];
   int              error_count;

   // Two-point calibrated output power, bad flag, and gain, current, voltage, input power.
   function automatic telemetry_type convert_readings(reading_set_type r);
      telemetry_type t;
      int    p, g;
      longint v, c;
      int    idx;
      logic [11:0] lo_tab [9];
      longint s_tab [9];
      longint b_tab [9];
      lo_tab = '{1515, 1188, 1005, 897, 825, 776, 746, 733, 725};
      s_tab  = '{144, 1003, 1789, 3034, 4548, 6685, 10925, 25205, 40960};
      b_tab  = '{2402360, 1103292, 166461, -1083166, -2443949, -4206343,
                 -7492927, -18148432, -29696000};
      t.bad = (cal_high <= cal_low);
      // high clamp is tested before the low one
      if (r.power > cal_high) p = 0;
      else if (r.power < cal_low) p = -30;
      else if (t.bad) p = 0;
      else p = -((30 * (int'(cal_high) - int'(r.power))) / (int'(cal_high) - int'(cal_low)));
      // gain: saturating ends, then the first segment whose lower bound is met
      if (r.gain >= 3781) g = 45;
      else if (r.gain < 725) g = 0;
      else begin
         g = 0;
         for (idx = 8; idx >= 0; idx--) begin
            if (r.gain >= lo_tab[idx]) begin
               v = s_tab[idx] * longint'(r.gain) + b_tab[idx];
               g = (v < 0) ? 0 : int'(v >>> 16);
            end
         end
      end
      c = (longint'(3280) * r.current) / 45056;
      if (c > 255) c = 255;
      v = (longint'(r.voltage) * 64'd31801355) >> 32;
      t.pout = p[5:0];
      t.gain = g[5:0];
      t.cur  = c[7:0];
      t.volt = v[4:0];
      p = p - g + int'(atten);
      t.pin  = p[7:0];
      return t;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Driver: one queued reading set per transfer, after its drawn gap.
   int gap_left;
   bit have_item;
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         have_item = 1'b0;
         gap_left = 0;
      end else begin
         if (start && !busy) begin
            expected_telemetry.push_back(convert_readings({req_power_sample,
               req_current_sample, req_gain_sample, req_voltage_sample}));
            have_item = 1'b0;
         end
         if (!have_item && pending_sets.size() > 0) begin
            reading_set_type r;
            r = pending_sets.pop_front();
            gap_left = pending_gaps.pop_front();
            {req_power_sample, req_current_sample, req_gain_sample, req_voltage_sample} <= r;
            have_item = 1'b1;
         end
         if (have_item && gap_left == 0) start <= 1'b1;
         else begin
            start <= 1'b0;
            if (have_item) gap_left--;
         end
      end
   end

   // Monitor: every done strobe is a transfer to be checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && done) begin
         if (expected_telemetry.size() == 0) begin
            $display("%0t unexpected result transfer", $realtime);
            error_count++;
         end else begin
            telemetry_type w;
            w = expected_telemetry.pop_front();
            if (rsp_output_power_dbm !== w.pout)
               report_mismatch("output_power_dbm", rsp_output_power_dbm, w.pout);
            if (rsp_gain_db !== w.gain) report_mismatch("gain_db", rsp_gain_db, w.gain);
            if (rsp_current_ma !== w.cur) report_mismatch("current_ma", rsp_current_ma, w.cur);
            if (rsp_voltage_v !== w.volt) report_mismatch("voltage_v", rsp_voltage_v, w.volt);
            if (rsp_input_power_dbm !== w.pin)
               report_mismatch("input_power_dbm", rsp_input_power_dbm, w.pin);
            if (rsp_calibration_bad !== w.bad)
               report_mismatch("calibration_bad", rsp_calibration_bad, w.bad);
         end
      end
   end

   task automatic queue_set(logic [11:0] p, logic [11:0] c, logic [11:0] g, logic [11:0] v,
                            int gap);
      pending_sets.push_back({p, c, g, v});
      pending_gaps.push_back(gap);
   endtask

   // Wait until every queued set has transferred and every result is back.
   task automatic drain();
      while (pending_sets.size() > 0 || have_item || start || expected_telemetry.size() > 0)
         @(posedge clock);
      repeat (14) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [11:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_CAL_HIGH: cal_high = val;
         CSR_CAL_LOW:  cal_low  = val;
         CSR_ATTEN:    atten    = val[4:0];
         default: ;
      endcase
   endtask

   // Random reading sets; gain codes biased towards the curve's breakpoints.
   task automatic queue_random(int n);
      logic [11:0] g;
      int k;
      for (k = 0; k < n; k++) begin
         case ($urandom_range(0, 3))
            0: g = 12'($urandom_range(700, 1600));
            1: g = 12'($urandom_range(3700, 3850));
            default: g = 12'($urandom);
         endcase
         queue_set(12'($urandom), 12'($urandom), g, 12'($urandom),
                   ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18));
      end
   endtask

   int ph;
   initial begin
      reset = 1'b1;
      start = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_CAL_HIGH;
      csr_wdata = '0;
      {req_power_sample, req_current_sample, req_gain_sample, req_voltage_sample} = '0;
      cal_high = CalHighReset;
      cal_low = CalLowReset;
      atten = AttenReset;
      error_count = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: defaults, field extremes, clamps and every gain breakpoint.
      queue_set(12'd0, 12'd0, 12'd0, 12'd0, 0);
      queue_set(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 0);
      queue_set(12'd1833, 12'd1000, 12'd3781, 12'd100, 0);
      queue_set(12'd1834, 12'd2000, 12'd3780, 12'd2000, 1);
      queue_set(12'd488, 12'd3000, 12'd725, 12'd3000, 0);
      queue_set(12'd487, 12'd45, 12'd724, 12'd4000, 2);
      queue_set(12'd1200, 12'd3500, 12'd733, 12'd555, 0);
      queue_set(12'd900, 12'd3504, 12'd746, 12'd135, 0);
      queue_set(12'd1600, 12'd14, 12'd776, 12'd136, 0);
      queue_set(12'd700, 12'd3505, 12'd825, 12'd4095, 0);
      queue_set(12'd1000, 12'd1, 12'd897, 12'd1, 0);
      queue_set(12'd1832, 12'd2, 12'd1005, 12'd2, 0);
      queue_set(12'd489, 12'd3, 12'd1188, 12'd3, 0);
      queue_set(12'd1500, 12'd4, 12'd1514, 12'd4, 0);
      queue_set(12'd1515, 12'd5, 12'd1515, 12'd5, 0);
      drain();

      // Several calibration settings, the extremes and a bad calibration among them.
      for (ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin write_reg(CSR_CAL_HIGH, 12'hFFF); write_reg(CSR_CAL_LOW, 12'd0);
                     write_reg(CSR_ATTEN, 12'd31); end
            1: begin write_reg(CSR_CAL_HIGH, 12'd1000); write_reg(CSR_CAL_LOW, 12'd1000);
                     write_reg(CSR_ATTEN, 12'hFE0); end
            2: begin write_reg(CSR_CAL_HIGH, 12'd200); write_reg(CSR_CAL_LOW, 12'd3000);
                     write_reg(CSR_ATTEN, 12'd17); end
            3: begin write_reg(CSR_CAL_HIGH, 12'd1); write_reg(CSR_CAL_LOW, 12'd0); end
            default: begin
               write_reg(CSR_CAL_LOW, 12'($urandom_range(0, 3000)));
               write_reg(CSR_CAL_HIGH, 12'($urandom_range(cal_low, 4095)));
               write_reg(CSR_ATTEN, 12'($urandom));
            end
         endcase
         queue_set(cal_high, 12'($urandom), 12'($urandom), 12'($urandom), 0);
         queue_set(cal_low, 12'($urandom), 12'($urandom), 12'($urandom), 0);
         queue_random(200);
         // pause the sender until everything outstanding is back
         drain();
      end
      if (error_count == 0) $display("tb_amplifier_telemetry_converter: done, clean");
      else $display("tb_amplifier_telemetry_converter: done, errors");
      $finish;
   end

   initial begin
      #400000;
      $display("tb_amplifier_telemetry_converter: done, errors");
      $finish;
   end

endmodule
